[hw/rtl/rhss_pkg.sv]
// ----------------------------------------------------------------------------
// rhss_pkg
// Shared types and constants of the rolling hash substring search block.
// ----------------------------------------------------------------------------
package rhss_pkg;

  localparam int HASH_W    = 31;
  localparam int SYM_W     = 8;
  localparam int POS_W     = 20;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam int RED_W     = 64;
  localparam int RED_STEPS = RED_W / 2;
  localparam int RED_CW    = $clog2(RED_STEPS);

  localparam logic [HASH_W-1:0] MODULUS_RESET = 31'd1000000007;
  localparam logic [HASH_W-1:0] BASE_RESET    = 31'd26;
  localparam logic [HASH_W-1:0] MODULUS_MIN   = 31'd2;

  typedef enum logic [1:0] {
    ST_MATCH    = 2'd0,
    ST_NO_MATCH = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_t;

  typedef enum logic {
    REG_MODULUS = 1'b0,
    REG_BASE    = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic             kind;
    logic [SYM_W-1:0] symbol;
    logic             last;
  } item_t;

  typedef struct packed {
    status_t          status;
    logic [POS_W-1:0] position;
  } result_t;

  typedef struct packed {
    logic [HASH_W-1:0] modulus_eff;
    logic [HASH_W-1:0] base;
    logic              modulus_wr;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [RED_W-1:0] x;
  } red_req_t;

  typedef struct packed {
    logic              done;
    logic [HASH_W-1:0] rem;
  } red_rsp_t;

endpackage

[hw/rtl/rhss_chan_if.sv]
// ----------------------------------------------------------------------------
// rhss_chan_if
// Valid/ready channel carrying one payload beat of type T.
// ----------------------------------------------------------------------------
interface rhss_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/rhss_apb_regs.sv]
// ----------------------------------------------------------------------------
// rhss_apb_regs
// APB register file holding the hash modulus and base.
// ----------------------------------------------------------------------------
module rhss_apb_regs
  import rhss_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [HASH_W-1:0] modulus;
  logic [HASH_W-1:0] base;
  logic              wr_en;
  reg_idx_t          idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_RESET;
      base    <= BASE_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_MODULUS: modulus <= pwdata[HASH_W-1:0];
        REG_BASE:    base    <= pwdata[HASH_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODULUS: prdata = {1'b0, modulus};
      REG_BASE:    prdata = {1'b0, base};
    endcase
  end

  // A modulus below two behaves as two.
  assign cfg.modulus_eff = (modulus < MODULUS_MIN) ? MODULUS_MIN : modulus;
  assign cfg.base        = base;
  assign cfg.modulus_wr  = wr_en && (idx == REG_MODULUS);

endmodule

[hw/rtl/rhss_modred.sv]
// ----------------------------------------------------------------------------
// rhss_modred
// Iterative reduction of a 64-bit value modulo a 31-bit modulus, two bits
// per cycle by restoring compare and subtract.
// ----------------------------------------------------------------------------
module rhss_modred
  import rhss_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [HASH_W-1:0] modulus,
  input  red_req_t          req,
  output red_rsp_t          rsp
);

  logic [RED_W-1:0]  sh;
  logic [HASH_W-1:0] r;
  logic [RED_CW-1:0] cnt;
  logic              busy;
  logic              done;

  logic [HASH_W:0]   t1, t2;
  logic [HASH_W+1:0] d1, d2;
  logic [HASH_W-1:0] r1, r2;

  // The partial remainder stays below the modulus, so each shifted value is
  // below twice the modulus and one conditional subtract restores it.
  always_comb begin
    t1 = {r, sh[RED_W-1]};
    d1 = {1'b0, t1} - {2'b00, modulus};
    r1 = d1[HASH_W+1] ? t1[HASH_W-1:0] : d1[HASH_W-1:0];
    t2 = {r1, sh[RED_W-2]};
    d2 = {1'b0, t2} - {2'b00, modulus};
    r2 = d2[HASH_W+1] ? t2[HASH_W-1:0] : d2[HASH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        sh   <= req.x;
        r    <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        sh  <= {sh[RED_W-3:0], 2'b00};
        r   <= r2;
        cnt <= cnt + 1'b1;
        if (cnt == RED_CW'(RED_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = r;

endmodule

[hw/rtl/rhss_core.sv]
// ----------------------------------------------------------------------------
// rhss_core
// Job sequencer: pattern and text hashing, window store, result register.
// ----------------------------------------------------------------------------
module rhss_core
  import rhss_pkg::*;
#(
  parameter int              PATTERN_MAX = 64,
  parameter longint unsigned TEXT_MAX    = 64'd1048576
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  rhss_chan_if.sink   item,
  rhss_chan_if.source result,
  output red_req_t  red_req,
  input  red_rsp_t  red_rsp
);

  localparam int AW  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int LW  = $clog2(PATTERN_MAX + 2);
  localparam int LW1 = LW + 1;
  localparam int TIW = $clog2(TEXT_MAX + 1);
  localparam int DW  = (TIW > LW) ? TIW : LW;
  localparam longint unsigned CAP =
    (TEXT_MAX - 1 > 64'hFFFFF) ? 64'hFFFFF : TEXT_MAX - 1;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_MUL, S_RED, S_CMP, S_FIN
  } state_t;

  typedef enum logic [2:0] {
    OP_PH, OP_BP, OP_PHFIX, OP_GONE, OP_TH
  } op_t;

  state_t state;
  op_t    op;

  item_t             in_q;
  logic [HASH_W-1:0] ph, th, bp, gone;
  logic [LW-1:0]     plen, fill;
  logic [AW-1:0]     slot;
  logic [TIW-1:0]    tidx;
  logic              sd, pclosed, ph_dirty;
  logic [2*HASH_W-1:0] prod;
  logic [HASH_W:0]   addend_q;
  logic              red_start;
  logic              res_pend;
  status_t           res_status;
  logic [POS_W-1:0]  res_pos;
  logic              out_valid;
  result_t           out_data;

  logic [SYM_W-1:0]  win_mem [PATTERN_MAX];
  logic [SYM_W-1:0]  mem_q;
  logic              mem_we;
  logic              mem_re;

  logic [HASH_W-1:0] mul_a, mul_b;
  logic [HASH_W:0]   addend;
  logic              full;
  logic [LW1-1:0]    slot_w, len_w, old_w;
  logic [AW-1:0]     old_slot, slot_next;
  logic              too_long;
  logic              want_out;
  logic [DW-1:0]     diff, pos;

  assign full     = (fill == plen);
  assign too_long = (plen > LW'(PATTERN_MAX));

  // Oldest byte of the window sits pattern-length slots behind the write slot.
  always_comb begin
    slot_w   = LW1'(slot);
    len_w    = LW1'(plen);
    old_w    = (slot_w >= len_w) ? slot_w - len_w : slot_w + LW1'(PATTERN_MAX) - len_w;
    old_slot = old_w[AW-1:0];
    slot_next = (slot_w == LW1'(PATTERN_MAX - 1)) ? '0 : slot + 1'b1;
  end

  always_comb begin
    mul_a  = ph;
    mul_b  = cfg.base;
    addend = '0;
    case (op)
      OP_PH: begin
        addend = (HASH_W+1)'(in_q.symbol);
      end
      OP_BP: begin
        mul_a = bp;
      end
      OP_PHFIX: begin
        mul_b = HASH_W'(1);
      end
      OP_GONE: begin
        mul_a = HASH_W'(mem_q);
        mul_b = bp;
      end
      OP_TH: begin
        mul_a  = th;
        addend = (HASH_W+1)'(in_q.symbol)
               + (full ? (HASH_W+1)'(cfg.modulus_eff) - (HASH_W+1)'(gone) : '0);
      end
      default: begin
        mul_a = ph;
      end
    endcase
  end

  assign red_req.start = red_start;
  assign red_req.x     = RED_W'(prod) + RED_W'(addend_q);

  // Start of the matching window, clamped to the reportable range.
  always_comb begin
    diff = (DW'(tidx) >= DW'(plen)) ? DW'(tidx) - DW'(plen) : '0;
    pos  = (diff > DW'(CAP)) ? DW'(CAP) : diff;
  end

  assign want_out = res_pend || (in_q.kind && in_q.last && !sd);

  assign mem_we = (state == S_RED) && (op == OP_TH) && red_rsp.done;
  assign mem_re = (state == S_READ);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_mem[slot] <= in_q.symbol;
    end
    if (mem_re) begin
      mem_q <= win_mem[old_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      op         <= OP_PH;
      ph         <= '0;
      th         <= '0;
      bp         <= HASH_W'(1);
      plen       <= '0;
      fill       <= '0;
      slot       <= '0;
      tidx       <= '0;
      sd         <= 1'b0;
      pclosed    <= 1'b0;
      ph_dirty   <= 1'b0;
      red_start  <= 1'b0;
      res_pend   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      red_start <= 1'b0;
      if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg.modulus_wr) begin
        ph_dirty <= 1'b1;
      end

      unique case (state)
        S_IDLE: begin
          if (item.valid) begin
            in_q <= item.data;
            if (!item.data.kind) begin
              if (!pclosed) begin
                if (!too_long) begin
                  plen <= plen + 1'b1;
                end
                op    <= OP_PH;
                state <= S_MUL;
              end
            end else begin
              // A text beat closes an open pattern first.
              if (!pclosed) begin
                pclosed <= 1'b1;
              end
              if (!pclosed && too_long) begin
                sd         <= 1'b1;
                res_pend   <= 1'b1;
                res_status <= ST_TOO_LONG;
                res_pos    <= '0;
                state      <= S_FIN;
              end else if (sd) begin
                state <= S_FIN;
              end else if (plen == '0) begin
                sd         <= 1'b1;
                res_pend   <= 1'b1;
                res_status <= ST_MATCH;
                res_pos    <= '0;
                state      <= S_FIN;
              end else if (ph_dirty) begin
                op    <= OP_PHFIX;
                state <= S_MUL;
              end else if (full) begin
                state <= S_READ;
              end else begin
                op    <= OP_TH;
                state <= S_MUL;
              end
            end
          end
        end

        S_READ: begin
          op    <= OP_GONE;
          state <= S_MUL;
        end

        S_MUL: begin
          prod      <= mul_a * mul_b;
          addend_q  <= addend;
          red_start <= 1'b1;
          state     <= S_RED;
        end

        S_RED: begin
          if (red_rsp.done) begin
            unique case (op)
              OP_PH: begin
                ph    <= red_rsp.rem;
                op    <= OP_BP;
                state <= S_MUL;
              end
              OP_BP: begin
                bp    <= red_rsp.rem;
                state <= S_FIN;
                if (in_q.last) begin
                  pclosed <= 1'b1;
                  if (too_long) begin
                    sd         <= 1'b1;
                    res_pend   <= 1'b1;
                    res_status <= ST_TOO_LONG;
                    res_pos    <= '0;
                  end
                end
              end
              OP_PHFIX: begin
                ph       <= red_rsp.rem;
                ph_dirty <= 1'b0;
                if (full) begin
                  state <= S_READ;
                end else begin
                  op    <= OP_TH;
                  state <= S_MUL;
                end
              end
              OP_GONE: begin
                gone  <= red_rsp.rem;
                op    <= OP_TH;
                state <= S_MUL;
              end
              OP_TH: begin
                th   <= red_rsp.rem;
                slot <= slot_next;
                if (!full) begin
                  fill <= fill + 1'b1;
                end
                if (tidx < TIW'(TEXT_MAX)) begin
                  tidx <= tidx + 1'b1;
                end
                state <= S_CMP;
              end
              default: begin
                state <= S_FIN;
              end
            endcase
          end
        end

        S_CMP: begin
          if (full && (th == ph)) begin
            sd         <= 1'b1;
            res_pend   <= 1'b1;
            res_status <= ST_MATCH;
            res_pos    <= POS_W'(pos);
          end
          state <= S_FIN;
        end

        S_FIN: begin
          if (!(want_out && out_valid && !result.ready)) begin
            if (want_out) begin
              out_valid <= 1'b1;
              if (res_pend) begin
                out_data.status   <= res_status;
                out_data.position <= res_pos;
              end else begin
                out_data.status   <= ST_NO_MATCH;
                out_data.position <= '0;
              end
            end
            res_pend <= 1'b0;
            // The final text beat ends the job and clears its state; modulus and base keep their values.
            if (in_q.kind && in_q.last) begin
              ph       <= '0;
              th       <= '0;
              bp       <= HASH_W'(1);
              plen     <= '0;
              fill     <= '0;
              slot     <= '0;
              tidx     <= '0;
              sd       <= 1'b0;
              pclosed  <= 1'b0;
              ph_dirty <= 1'b0;
            end
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign item.ready   = (state == S_IDLE);
  assign result.valid = out_valid;
  assign result.data  = out_data;

endmodule

[hw/rtl/rolling_hash_substring_search.sv]
// ----------------------------------------------------------------------------
// rolling_hash_substring_search
// Rolling polynomial hash substring search over a stream of pattern and
// text bytes, with an APB port for the modulus and base.
// ----------------------------------------------------------------------------
// Usage: send the pattern as beats with kind 0, then the text as beats with
// kind 1, each group closed by a beat with last set. The item channel takes
// one byte per beat; the result channel gives at most one beat per job: a
// match with its start position, no match at the final text byte, or a
// pattern that does not fit the window store.
// Hashing runs on one shared reducer that retires two bits a cycle; each
// reduction follows its multiply. A pattern byte needs two reductions; a
// text byte needs one while the window fills, two once it is full and none
// after the job has its result. The first text byte after a modulus write
// needs one more reduction to re-reduce the pattern hash.
// The result sits in the output register at the end of its byte. The next
// byte is taken while it waits; a second result holds the item channel until
// the receiver accepts the first. Reset (rst, synchronous) clears the job and
// restores the modulus and base; the window store is not cleared, since each
// slot is written before it is read within a job.
// ----------------------------------------------------------------------------
module rolling_hash_substring_search
  import rhss_pkg::*;
#(
  parameter int              PATTERN_MAX = 64,
  parameter longint unsigned TEXT_MAX    = 64'd1048576
) (
  input  logic              clk,
  input  logic              rst,
  rhss_chan_if.sink         item,
  rhss_chan_if.source       result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t     cfg;
  red_req_t red_req;
  red_rsp_t red_rsp;

  // Modulus and base registers; the modulus is presented already clamped.
  rhss_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Shared reducer: every product and sum is reduced here, one at a time.
  rhss_modred u_modred (
    .clk     (clk),
    .rst     (rst),
    .modulus (cfg.modulus_eff),
    .req     (red_req),
    .rsp     (red_rsp)
  );

  // Sequencer with the window store and the output register.
  rhss_core #(
    .PATTERN_MAX (PATTERN_MAX),
    .TEXT_MAX    (TEXT_MAX)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .item    (item),
    .result  (result),
    .red_req (red_req),
    .red_rsp (red_rsp)
  );

endmodule

[dv/tb_rolling_hash_substring_search.sv]
// ----------------------------------------------------------------------------
// tb_rolling_hash_substring_search
// Self-checking bench for the rolling hash substring search block. Pattern
// and text jobs are streamed through the item channel under several modulus
// and base settings. Every accepted beat runs through a local rolling hash
// search predictor, and each result beat is checked against the oldest
// outstanding verdict.
// ----------------------------------------------------------------------------
module tb_rolling_hash_substring_search
  import rhss_pkg::*;
();

  localparam int              WINDOW_DEPTH  = 64;
  localparam longint unsigned SCAN_LIMIT    = 64'd1048576;
  localparam longint unsigned POS_CAP       = 64'd1048575;
  localparam int              PHASES        = 7;
  localparam int              PHASE_BEATS   = 180;
  localparam int              SETTLE_CYCLES = 200;
  localparam int              HOLD_CYCLES   = 1500;
  localparam int              QUIET_LIMIT   = 6000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  // Item and result channels. The bench owns the source side of the item
  // channel and the ready of the result channel through plain variables, so
  // every input of the block is known from time zero.
  rhss_chan_if #(.T(item_t))   item_ch ();
  rhss_chan_if #(.T(result_t)) result_ch ();

  logic  beat_valid = 1'b0;
  item_t beat_data  = '0;
  logic  accept_r   = 1'b0;

  assign item_ch.valid   = beat_valid;
  assign item_ch.data    = beat_data;
  assign result_ch.ready = accept_r;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  rolling_hash_substring_search u_top (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Stimulus and checking state.
  item_t   byte_queue [$];
  result_t awaited_verdicts [$];
  int      failures          = 0;
  int      phase_beats       = 0;
  int      sender_idle_pct   = 0;
  int      receiver_idle_pct = 0;
  int      hold_requests     = 0;
  int      hold_served       = 0;
  int      hold_left         = 0;
  int      quiet_cycles      = 0;
  logic    item_fire         = 1'b0;

  // Predictor copy of the registers and of the search job.
  logic [HASH_W-1:0] modulus_reg;
  logic [HASH_W-1:0] base_reg;
  longint unsigned   key_hash;
  longint unsigned   scan_hash;
  longint unsigned   key_pow;
  int unsigned       key_len;
  longint unsigned   scan_count;
  logic [SYM_W-1:0]  ring [WINDOW_DEPTH];
  bit                hunt_over;
  bit                key_sealed;
  int unsigned       ring_fill;
  int unsigned       ring_head;

  function automatic longint unsigned mod_mul(input longint unsigned a,
                                              input longint unsigned b,
                                              input longint unsigned m);
    return ((a % m) * (b % m)) % m;
  endfunction

  // Drops the job state. The registers are left alone.
  function automatic void clear_search();
    key_hash   = 0;
    scan_hash  = 0;
    key_pow    = 1;
    key_len    = 0;
    scan_count = 0;
    hunt_over  = 1'b0;
    key_sealed = 1'b0;
    ring_fill  = 0;
    ring_head  = 0;
    foreach (ring[i]) ring[i] = '0;
  endfunction

  // Closing the pattern reports an overflow when it holds more bytes than the
  // window store; such a job then ignores its text.
  function automatic bit seal_key(output result_t verdict);
    verdict    = '0;
    key_sealed = 1'b1;
    if (key_len > WINDOW_DEPTH) begin
      hunt_over        = 1'b1;
      verdict.status   = ST_TOO_LONG;
      verdict.position = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advances the search by one accepted beat. Returns 1 when the beat yields
  // a result, which is then left in verdict.
  function automatic bit search_step(input item_t it, output result_t verdict);
    longint unsigned m;
    longint unsigned b;
    longint unsigned gone;
    longint unsigned pos;
    int unsigned     old_slot;
    bit              hit;
    hit     = 1'b0;
    verdict = '0;
    m = (modulus_reg < MODULUS_MIN) ? 64'd2 : 64'(modulus_reg);
    b = 64'(base_reg) % m;

    if (!it.kind) begin
      // Pattern bytes after the pattern is closed are dropped.
      if (!key_sealed) begin
        key_hash = (mod_mul(key_hash, b, m) + it.symbol % m) % m;
        key_pow  = mod_mul(key_pow, b, m);
        if (key_len <= WINDOW_DEPTH) key_len++;
        if (it.last) hit = seal_key(verdict);
      end
      return hit;
    end

    // A text byte closes a pattern that is still open, possibly empty.
    if (!key_sealed) hit = seal_key(verdict);

    if (!hunt_over && !hit) begin
      if (key_len == 0) begin
        // The empty pattern matches at the very first text byte.
        hunt_over        = 1'b1;
        hit              = 1'b1;
        verdict.status   = ST_MATCH;
        verdict.position = '0;
      end else begin
        if (ring_fill < key_len) begin
          scan_hash = (mod_mul(scan_hash, b, m) + it.symbol % m) % m;
          ring_fill++;
        end else begin
          // Full window: take the oldest byte out before the new one goes in.
          old_slot  = (ring_head + WINDOW_DEPTH - key_len) % WINDOW_DEPTH;
          gone      = mod_mul(ring[old_slot], key_pow, m);
          scan_hash = (mod_mul(scan_hash, b, m) + m - gone + it.symbol % m) % m;
        end
        ring[ring_head % WINDOW_DEPTH] = it.symbol;
        ring_head = (ring_head + 1) % WINDOW_DEPTH;
        if (scan_count < SCAN_LIMIT) scan_count++;
        // Equal hashes count as a hit; collisions are not resolved.
        if (ring_fill == key_len && scan_hash == key_hash % m) begin
          hunt_over = 1'b1;
          hit       = 1'b1;
          pos       = (scan_count >= key_len) ? scan_count - key_len : 0;
          if (pos > POS_CAP) pos = POS_CAP;
          verdict.status   = ST_MATCH;
          verdict.position = pos[POS_W-1:0];
        end
      end
    end

    if (it.last) begin
      // End of text: report no match unless the job already reported.
      if (!hit && !hunt_over) begin
        hit              = 1'b1;
        verdict.status   = ST_NO_MATCH;
        verdict.position = '0;
      end
      clear_search();
    end
    return hit;
  endfunction

  // --------------------------------------------------------------------------
  // Driver. A new beat is offered at the falling edge once the previous one
  // went through, unless the sender takes a random gap.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst && (!beat_valid || item_fire)) begin
      if (byte_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        beat_valid <= 1'b1;
        beat_data  <= byte_queue.pop_front();
      end else begin
        beat_valid <= 1'b0;
      end
    end
  end

  // Receiver. A hold request blocks the result channel for a long stretch,
  // counted here, so that a second result backs up into the item channel.
  always @(negedge clk) begin
    if (rst) begin
      accept_r <= 1'b0;
    end else if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      accept_r    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      accept_r  <= 1'b0;
    end else begin
      accept_r <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Both channels are sampled at the rising edge. Accepted item
  // beats feed the predictor; accepted result beats are compared with the
  // oldest outstanding verdict. A long stretch with no beat on either
  // channel ends the run as a hang.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t predicted;
    result_t seen;
    result_t oldest;
    bit      result_fire;
    if (rst) begin
      item_fire    = 1'b0;
      quiet_cycles = 0;
    end else begin
      item_fire   = beat_valid && item_ch.ready;
      result_fire = result_ch.valid && accept_r;
      if (result_fire) begin
        seen = result_ch.data;
        if (awaited_verdicts.size() == 0) begin
          $error("unexpected result beat: status %0d, position %0d",
                 seen.status, seen.position);
          failures++;
        end else begin
          oldest = awaited_verdicts.pop_front();
          if (seen.status !== oldest.status) begin
            $error("status: expected %0d, got %0d", oldest.status, seen.status);
            failures++;
          end
          if (seen.position !== oldest.position) begin
            $error("position: expected %0d, got %0d",
                   oldest.position, seen.position);
            failures++;
          end
        end
      end
      if (item_fire && search_step(beat_data, predicted))
        awaited_verdicts.push_back(predicted);

      if (item_fire || result_fire) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("rolling_hash_substring_search: mismatch");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  task automatic push_beat(input logic kind, input logic [SYM_W-1:0] symbol,
                           input logic last);
    item_t it;
    it.kind   = kind;
    it.symbol = symbol;
    it.last   = last;
    byte_queue.push_back(it);
    phase_beats++;
  endtask

  // Waits until every queued beat is taken and every verdict has come back,
  // then gives the block time to finish a byte that yields no result.
  task automatic settle();
    while (byte_queue.size() != 0 || beat_valid || awaited_verdicts.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle; pready is always high.
  task automatic write_register(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ADDR_W'(int'(idx) * 4);
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      REG_MODULUS: modulus_reg = value[HASH_W-1:0];
      REG_BASE:    base_reg    = value[HASH_W-1:0];
      default:     ;
    endcase
  endtask

  // A span of zero draws from all byte values; otherwise from a narrow
  // alphabet starting at lo, which makes real and colliding hits common.
  function automatic logic [SYM_W-1:0] draw_symbol(input int lo, input int span);
    return SYM_W'((span == 0) ? $urandom_range(255) : lo + $urandom_range(span - 1));
  endfunction

  // Queues one job: the pattern, optional stray pattern bytes after it is
  // closed, then the text, which may carry a planted copy of the pattern.
  task automatic queue_job(input int plen, input int tlen, input bit sealed,
                           input int strays, input int span, input bit plant);
    logic [SYM_W-1:0] pat [$];
    logic [SYM_W-1:0] txt [$];
    int               lo;
    int               at;
    lo = (span == 0) ? 0 : $urandom_range(256 - span);
    for (int i = 0; i < plen; i++) pat.push_back(draw_symbol(lo, span));
    for (int i = 0; i < tlen; i++) txt.push_back(draw_symbol(lo, span));
    if (plant && plen > 0 && tlen >= plen) begin
      at = $urandom_range(tlen - plen);
      for (int i = 0; i < plen; i++) txt[at + i] = pat[i];
    end
    for (int i = 0; i < plen; i++) push_beat(1'b0, pat[i], sealed && i == plen - 1);
    if (sealed && plen > 0) begin
      for (int i = 0; i < strays; i++)
        push_beat(1'b0, draw_symbol(0, 0), 1'($urandom_range(1)));
    end
    for (int i = 0; i < tlen; i++) push_beat(1'b1, txt[i], i == tlen - 1);
  endtask

  // Mostly short patterns with texts that often contain them; now and then a
  // pattern that nearly or fully fills the window, an empty one, or one that overflows it.
  task automatic queue_random_job();
    int plen;
    int tlen;
    int roll;
    int span;
    roll = $urandom_range(99);
    if (roll < 3)       plen = $urandom_range(70, 65);
    else if (roll < 8)  plen = $urandom_range(64, 56);
    else if (roll < 18) plen = 0;
    else                plen = $urandom_range(6, 1);
    if (plen > WINDOW_DEPTH)          tlen = $urandom_range(5, 1);
    else if ($urandom_range(9) == 0)  tlen = $urandom_range(3, 1);
    else                              tlen = plen + $urandom_range(12);
    if (tlen == 0) tlen = 1;
    roll = $urandom_range(9);
    span = (roll < 4) ? 2 : (roll < 6) ? 4 : 0;
    queue_job(plen, tlen, $urandom_range(9) != 0,
              ($urandom_range(9) == 0) ? $urandom_range(3, 1) : 0,
              span, $urandom_range(4) < 3);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence. Each phase applies one register setting while the block is
  // idle, picks an idling pattern, and queues its jobs. Phase zero runs on
  // the reset values and opens with the directed cases; the last phase opens
  // with the long receiver hold.
  // --------------------------------------------------------------------------
  initial begin
    modulus_reg = MODULUS_RESET;
    base_reg    = BASE_RESET;
    clear_search();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        1: begin
          // Largest values; bit 31 of the write data is not part of the register.
          write_register(REG_MODULUS, 32'hFFFF_FFFF);
          write_register(REG_BASE, 32'h7FFF_FFFE);
        end
        2: begin
          write_register(REG_MODULUS, 32'd2);
          write_register(REG_BASE, 32'd1);
        end
        3: begin
          // A modulus below two behaves as two; a zero base kills all weights.
          write_register(REG_MODULUS, 32'd0);
          write_register(REG_BASE, 32'd0);
        end
        4: begin
          // Base larger than the modulus is used reduced.
          write_register(REG_MODULUS, 32'd101);
          write_register(REG_BASE, 32'd256);
        end
        5: begin
          write_register(REG_MODULUS, 32'd1);
          write_register(REG_BASE, 32'd3);
        end
        6: begin
          write_register(REG_MODULUS, 32'd1000000007);
          write_register(REG_BASE, 32'($urandom_range(32'h7FFF_FFFE, 1)));
        end
        default: ;
      endcase

      @(posedge clk);
      if (phase < 3) begin
        sender_idle_pct   = 28;
        receiver_idle_pct = 53;
      end else if (phase < 5) begin
        sender_idle_pct   = 53;
        receiver_idle_pct = 28;
      end else begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      phase_beats = 0;

      if (phase == 0) begin
        // Empty pattern: the first text byte matches at position zero.
        push_beat(1'b1, 8'h00, 1'b1);
        // One-byte pattern found at position one; the bytes after the hit
        // are skipped and the final one gives no second result.
        push_beat(1'b0, 8'hFF, 1'b1);
        push_beat(1'b1, 8'h00, 1'b0);
        push_beat(1'b1, 8'hFF, 1'b0);
        push_beat(1'b1, 8'h12, 1'b0);
        push_beat(1'b1, 8'h34, 1'b1);
        // Pattern byte after the pattern closed is dropped, and a text
        // shorter than the pattern ends with no match.
        push_beat(1'b0, 8'h41, 1'b0);
        push_beat(1'b0, 8'h42, 1'b1);
        push_beat(1'b0, 8'h43, 1'b0);
        push_beat(1'b1, 8'h41, 1'b1);
        // Pattern left open: the first text byte closes it.
        push_beat(1'b0, 8'h00, 1'b0);
        push_beat(1'b0, 8'h80, 1'b0);
        push_beat(1'b1, 8'h01, 1'b0);
        push_beat(1'b1, 8'h00, 1'b0);
        push_beat(1'b1, 8'h80, 1'b1);
        // Plain miss.
        push_beat(1'b0, 8'h7F, 1'b1);
        push_beat(1'b1, 8'h01, 1'b0);
        push_beat(1'b1, 8'h02, 1'b1);
        // Pattern one byte too long for the window store.
        queue_job(WINDOW_DEPTH + 1, 2, 1'b1, 0, 0, 1'b0);
      end

      if (phase == PHASES - 1) begin
        // Long receiver hold while one-beat jobs keep coming: each yields a
        // match, so results pile up and the item channel stalls.
        hold_requests++;
        for (int i = 0; i < 24; i++) push_beat(1'b1, draw_symbol(0, 0), 1'b1);
      end

      while (phase_beats < PHASE_BEATS) queue_random_job();
    end

    settle();
    if (failures == 0) begin
      $display("rolling_hash_substring_search: match");
    end else begin
      $display("rolling_hash_substring_search: mismatch");
    end
    $finish;
  end

endmodule
